[design/uer_pkg.sv]
// package for the ultrasonic echo ranger: widths, phase codes, microcode
// words and the control store; no dependencies
package uer_pkg;

    localparam int TICK_W   = 16;
    localparam int DIST_W   = 19;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // ceil(2^30 / 1000), exact for 17 * width below 2^21
    localparam int RECIP_SHIFT = 30;
    localparam logic [MUL_B_W-1:0] SOUND_RECIP = 21'd1073742;
    localparam logic [MUL_B_W-1:0] SOUND_NUM   = 21'd17;
    localparam int QUOT_W = 11;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;
    localparam logic [WEIGHT_W-1:0] ROUND_HALF = 16'd16384;

    localparam logic [TICK_W-1:0] TRIG_LOW_TICKS    = 16'd2;
    localparam logic [TICK_W-1:0] TRIG_HIGH_TICKS   = 16'd5;
    localparam logic [TICK_W-1:0] LISTEN_WAIT_TICKS = 16'd750;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO_US      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_US           = 8'd3;

    // measurement phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT      = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;
    localparam logic [2:0] PH_GAP       = 3'd5;

    // datapath operations
    localparam logic [2:0] OP_NOP        = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_MUL_SCALE  = 3'd3;
    localparam logic [2:0] OP_MUL_RECIP  = 3'd4;
    localparam logic [2:0] OP_MUL_WEIGHT = 3'd5;
    localparam logic [2:0] OP_MAC        = 3'd6;
    localparam logic [2:0] OP_EMIT       = 3'd7;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_NO_INPUT = 2'd1;
    localparam logic [1:0] COND_NO_BLEND = 2'd2;
    localparam logic [1:0] COND_OUT_BUSY = 2'd3;

    localparam int STEP_W = 3;

    // program steps
    localparam logic [STEP_W-1:0] ST_FETCH   = 3'd0;
    localparam logic [STEP_W-1:0] ST_TICK    = 3'd1;
    localparam logic [STEP_W-1:0] ST_SCALE   = 3'd2;
    localparam logic [STEP_W-1:0] ST_RECIP   = 3'd3;
    localparam logic [STEP_W-1:0] ST_WEIGHT  = 3'd4;
    localparam logic [STEP_W-1:0] ST_MAC     = 3'd5;
    localparam logic [STEP_W-1:0] ST_HOLD    = 3'd6;
    localparam logic [STEP_W-1:0] ST_EMIT    = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [2:0] op;
        logic       accept;
    } ctrl_t;

    typedef struct packed {
        logic              drive_en;
        logic              drive_lvl;
        logic              valid;
        logic              tmo;
        logic [DIST_W-1:0] smoothed;
    } result_t;

    // control store: jump to target when the condition holds, else fall through
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            ST_FETCH:  w = '{op: OP_LOAD,       cond: COND_NO_INPUT, target: ST_FETCH};
            ST_TICK:   w = '{op: OP_TICK,       cond: COND_NO_BLEND, target: ST_HOLD};
            ST_SCALE:  w = '{op: OP_MUL_SCALE,  cond: COND_ALWAYS,   target: ST_RECIP};
            ST_RECIP:  w = '{op: OP_MUL_RECIP,  cond: COND_ALWAYS,   target: ST_WEIGHT};
            ST_WEIGHT: w = '{op: OP_MUL_WEIGHT, cond: COND_ALWAYS,   target: ST_MAC};
            ST_MAC:    w = '{op: OP_MAC,        cond: COND_ALWAYS,   target: ST_HOLD};
            ST_HOLD:   w = '{op: OP_NOP,        cond: COND_OUT_BUSY, target: ST_HOLD};
            ST_EMIT:   w = '{op: OP_EMIT,       cond: COND_ALWAYS,   target: ST_FETCH};
            default:   w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

[design/uer_seq.sv]
// microcode sequencer: step counter, control store lookup and jump logic
// depends on uer_pkg
module uer_seq
    import uer_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_busy,
    input  logic  blend_req,
    output logic  in_ready,
    output ctrl_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              take;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !in_valid;
            COND_NO_BLEND: take = !blend_req;
            COND_OUT_BUSY: take = out_busy;
            default:       take = 1'b1;
        endcase
        step_next = take ? word.target : step_reg + 1'b1;
    end

    assign in_ready    = (word.op == OP_LOAD);
    assign ctrl.op     = word.op;
    assign ctrl.accept = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[design/uer_dp.sv]
// datapath: phase timer, echo width, shared multiplier and smoothed distance
// depends on uer_pkg
module uer_dp
    import uer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctrl,
    input  logic                echo_level,
    input  logic                measure_enable,
    input  logic [TICK_W-1:0]   max_echo_us,
    input  logic [WEIGHT_W-1:0] smoothing_weight,
    input  logic [TICK_W-1:0]   gap_us,
    output logic                blend_req,
    output result_t             result
);

    logic                level_reg;
    logic [2:0]          phase_reg;
    logic [2:0]          phase_next;
    logic [TICK_W-1:0]   ticks_reg;
    logic [TICK_W-1:0]   ticks_next;
    logic [DIST_W-1:0]   smooth_reg;
    logic [DIST_W-1:0]   smooth_next;
    logic [MUL_P_W-1:0]  acc_reg;
    logic [MUL_P_W-1:0]  acc_next;
    logic [3:0]          flags_reg;
    logic [3:0]          flags_next;

    logic [2:0]          ph;
    logic [TICK_W-1:0]   t;
    logic [TICK_W-1:0]   t1;
    logic                den;
    logic                dlvl;
    logic                tmo;
    logic                blend;

    logic [WEIGHT_W-1:0] w_sat;
    logic [WEIGHT_W-1:0] w_inv;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  prod;
    logic [35:0]         mac_sum;

    // per-tick phase sequencing
    always_comb
    begin
        ph    = PH_IDLE;
        t     = '0;
        den   = 1'b0;
        dlvl  = 1'b0;
        tmo   = 1'b0;
        blend = 1'b0;
        if (measure_enable)
        begin
            ph = (phase_reg == PH_IDLE) ? PH_TRIG_LOW : phase_reg;
            t  = (phase_reg == PH_IDLE) ? '0 : ticks_reg;
        end
        t1         = t + 1'b1;
        phase_next = ph;
        ticks_next = t1;
        case (ph)
            PH_TRIG_LOW:
            begin
                den = 1'b1;
                if (t1 >= TRIG_LOW_TICKS)
                begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                den  = 1'b1;
                dlvl = 1'b1;
                if (t1 >= TRIG_HIGH_TICKS)
                begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (t1 >= LISTEN_WAIT_TICKS)
                begin
                    phase_next = PH_MEASURE;
                    ticks_next = '0;
                end
            end
            PH_MEASURE:
            begin
                if (level_reg)
                begin
                    if (t1 >= max_echo_us)
                    begin
                        tmo        = 1'b1;
                        phase_next = PH_TRIG_LOW;
                        ticks_next = '0;
                    end
                end
                else if (t >= max_echo_us)
                begin
                    tmo        = 1'b1;
                    phase_next = PH_TRIG_LOW;
                    ticks_next = '0;
                end
                else
                begin
                    blend      = 1'b1;
                    phase_next = (gap_us == '0) ? PH_TRIG_LOW : PH_GAP;
                    ticks_next = '0;
                end
            end
            PH_GAP:
            begin
                if (t1 >= gap_us)
                begin
                    phase_next = PH_TRIG_LOW;
                    ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    assign blend_req = (ctrl.op == OP_TICK) && blend;

    // shared multiplier and its operand selection
    always_comb
    begin
        w_sat = (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
        w_inv = WEIGHT_ONE - w_sat;
        case (ctrl.op)
            OP_MUL_SCALE:
            begin
                mul_a = MUL_A_W'(acc_reg[TICK_W-1:0]);
                mul_b = SOUND_NUM;
            end
            OP_MUL_RECIP:
            begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = SOUND_RECIP;
            end
            OP_MUL_WEIGHT:
            begin
                mul_a = MUL_A_W'(w_sat);
                mul_b = MUL_B_W'({acc_reg[RECIP_SHIFT +: QUOT_W], 8'd0});
            end
            OP_MAC:
            begin
                mul_a = MUL_A_W'(w_inv);
                mul_b = MUL_B_W'(smooth_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod        = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        mac_sum     = acc_reg[35:0] + prod[35:0] + 36'(ROUND_HALF);
        smooth_next = mac_sum[15 +: DIST_W];
    end

    always_comb
    begin
        acc_next   = acc_reg;
        flags_next = flags_reg;
        case (ctrl.op)
            OP_TICK:
            begin
                acc_next   = MUL_P_W'(t);
                flags_next = {den, dlvl, blend, tmo};
            end
            OP_MUL_SCALE,
            OP_MUL_RECIP,
            OP_MUL_WEIGHT:
            begin
                acc_next = prod;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ticks_reg  <= '0;
            smooth_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            if (ctrl.op == OP_TICK)
            begin
                phase_reg <= phase_next;
                ticks_reg <= ticks_next;
            end
            if (ctrl.op == OP_MAC)
            begin
                smooth_reg <= smooth_next;
            end
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctrl.accept)
        begin
            level_reg <= echo_level;
        end
    end

    assign result.drive_en  = flags_reg[3];
    assign result.drive_lvl = flags_reg[2];
    assign result.valid     = flags_reg[1];
    assign result.tmo       = flags_reg[0];
    assign result.smoothed  = smooth_reg;

endmodule

[design/ultrasonic_echo_ranger_top.sv]
// Single-pin ultrasonic rangefinder. Each input item is one microsecond tick
// with the sampled pin level; each tick yields one result item with the pin
// drive, update and timeout flags and the smoothed distance (cm, 8 fraction
// bits). A tick runs the steps fetch, tick, hold and emit; the tick that closes
// an echo measurement adds four passes through the shared multiplier (scale,
// divide by reciprocal, weight, blend). The next tick is taken while a result
// still waits in the output register; the program stalls before writing it
// only if the previous result is untaken. Registers are to be written on the
// config channel between ticks; the block itself does not enforce this.
// depends on uer_pkg, uer_seq, uer_dp
module ultrasonic_echo_ranger_top
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] echo_level
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] pin_drive_enable, [1] pin_drive_level,
                                             // [2] distance_valid, [3] timeout_flag,
                                             // [22:4] smoothed_cm
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    logic                  enable_reg;
    logic [TICK_W-1:0]     max_echo_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [TICK_W-1:0]     gap_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    ctrl_t                 ctrl;
    result_t               result;
    logic                  blend_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            max_echo_reg <= 16'd30000;
            weight_reg   <= 16'd16384;
            gap_reg      <= 16'd20000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MEASURE_ENABLE:   enable_reg   <= cfg_data[0];
                REG_MAX_ECHO_US:      max_echo_reg <= cfg_data;
                REG_SMOOTHING_WEIGHT: weight_reg   <= cfg_data;
                REG_GAP_US:           gap_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    uer_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_busy  (out_valid_reg),
        .blend_req (blend_req),
        .in_ready  (s_tready),
        .ctrl      (ctrl)
    );

    uer_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .echo_level       (s_tdata[0]),
        .measure_enable   (enable_reg),
        .max_echo_us      (max_echo_reg),
        .smoothing_weight (weight_reg),
        .gap_us           (gap_reg),
        .blend_req        (blend_req),
        .result           (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_EMIT)
        begin
            out_data_reg <= {1'b0, result.smoothed, result.tmo, result.valid,
                             result.drive_lvl, result.drive_en};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
